>>> sv/sorted_input_range_mapper_macros.svh
// Assertion macros used by the sorted input range mapper RTL.
`ifndef SORTED_INPUT_RANGE_MAPPER_MACROS_SVH
`define SORTED_INPUT_RANGE_MAPPER_MACROS_SVH
`ifndef SYNTH
`define SRM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srm assertion failed");
`define SRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srm assertion failed");
`else
`define SRM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SRM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> sv/srm_pkg.sv
// Shared types and constants of the sorted input range mapper.
package srm_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS = 16;
  localparam int RES_W = $clog2(MAX_RESULTS + 1);

  localparam logic CMD_EVENT = 1'b1;

  localparam logic [1:0] KIND_LEVEL = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_FULL = 2'd2;

  typedef enum logic {
    OP_INSERT,
    OP_EVENT
  } op_t;

  typedef struct packed {
    logic               cmd;
    logic [15:0]        source_id;
    logic signed [15:0] source_value;
    logic signed [15:0] range_low;
    logic signed [15:0] range_high;
    logic [15:0]        dest_button;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  player_out;
    logic [15:0] button_out;
    logic        level;
    logic        last;
  } out_item_t;

  typedef struct packed {
    op_t                op;
    logic [15:0]        key;
    logic signed [15:0] value;
    logic signed [15:0] low;
    logic signed [15:0] high;
    logic [15:0]        dest;
  } cmd_t;

  typedef struct packed {
    logic [15:0]        key;
    logic signed [15:0] low;
    logic signed [15:0] high;
    logic [15:0]        dest;
    logic signed [15:0] last_value;
    logic               level;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_PLACE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR,
    S_EMIT,
    S_BACK_RD,
    S_BACK_CMP,
    S_FWD_RD,
    S_FWD_CHK,
    S_FLUSH
  } state_t;

endpackage

>>> sv/srm_front.sv
// Input side: accepts transactions, decodes the command and queues it for the back end.
module srm_front (
  input  logic             clk,
  input  logic             rst,
  input  srm_pkg::in_item_t in_item,
  input  logic             in_valid,
  output logic             in_ready,
  output srm_pkg::cmd_t    q_item,
  output logic             q_valid,
  input  logic             q_ready
);
  import srm_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       decoded;
  logic       push;
  logic       pop;

  always_comb begin
    decoded.op    = (in_item.cmd == CMD_EVENT) ? OP_EVENT : OP_INSERT;
    decoded.key   = in_item.source_id;
    decoded.value = in_item.source_value;
    decoded.low   = in_item.range_low;
    decoded.high  = in_item.range_high;
    decoded.dest  = in_item.dest_button;
  end

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> sv/srm_back.sv
// Command execution: sorted table memory, binary search, insert shift and event walk.
module srm_back #(
  parameter int TABLE_DEPTH = srm_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  srm_pkg::cmd_t      q_item,
  input  logic               q_valid,
  output logic               q_ready,
  output srm_pkg::out_item_t out_item,
  output logic               out_valid,
  input  logic               out_ready
);
  import srm_pkg::*;
  `include "sorted_input_range_mapper_macros.svh"

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  entry_t           mem [TABLE_DEPTH];
  entry_t           rdata;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  state_t           state;
  state_t           state_next;
  cmd_t             cur;
  logic [7:0]       player_id;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] sh;
  logic             hit;
  logic             full;
  logic             hold_valid;
  logic [15:0]      hold_button;
  logic             hold_level;
  logic [RES_W-1:0] res_cnt;

  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] sh_m1;
  logic [CNT_W-1:0] pos_m1;
  logic             out_free;
  logic             out_load;
  out_item_t        out_next;
  logic             changed;
  logic             new_level;
  logic             report;
  logic             walk_go;
  logic             key_match;

  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid       = mid_sum[CNT_W:1];
  assign sh_m1     = sh - CNT_W'(1);
  assign pos_m1    = pos - CNT_W'(1);
  assign out_free  = !out_valid || out_ready;
  assign key_match = (rdata.key == cur.key);
  assign changed   = (cur.value != rdata.last_value);
  assign new_level = ($signed(cur.value) >= $signed(rdata.low)) &&
                     ($signed(cur.value) <= $signed(rdata.high));
  assign report    = changed && (new_level != rdata.level) &&
                     (res_cnt < RES_W'(MAX_RESULTS));
  assign walk_go   = !(report && hold_valid && !out_free);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.op == OP_INSERT && count == CNT_W'(TABLE_DEPTH)) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_SRCH;
          end
        end
      end
      S_SRCH:     state_next = (lo < hi) ? S_CMP : S_PLACE;
      S_CMP:      state_next = (cur.key == rdata.key) ? S_PLACE : S_SRCH;
      S_PLACE: begin
        if (cur.op == OP_INSERT) begin
          state_next = (sh > pos) ? S_SHIFT_RD : S_INS_WR;
        end else begin
          state_next = hit ? S_BACK_RD : S_IDLE;
        end
      end
      S_SHIFT_RD: state_next = S_SHIFT_WR;
      S_SHIFT_WR: state_next = (sh_m1 > pos) ? S_SHIFT_RD : S_INS_WR;
      S_INS_WR:   state_next = S_EMIT;
      S_EMIT:     state_next = out_free ? S_IDLE : S_EMIT;
      S_BACK_RD:  state_next = (pos == '0) ? S_FWD_RD : S_BACK_CMP;
      S_BACK_CMP: state_next = key_match ? S_BACK_RD : S_FWD_RD;
      S_FWD_RD:   state_next = (pos < count) ? S_FWD_CHK : S_FLUSH;
      S_FWD_CHK: begin
        if (!key_match) begin
          state_next = S_FLUSH;
        end else if (walk_go) begin
          state_next = S_FWD_RD;
        end
      end
      S_FLUSH:    state_next = (!hold_valid || out_free) ? S_IDLE : S_FLUSH;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_ready  = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = pos[IDX_W-1:0];
    wr_en    = 1'b0;
    wr_addr  = pos[IDX_W-1:0];
    wr_data  = rdata;
    out_load = 1'b0;
    out_next.kind       = KIND_LEVEL;
    out_next.player_out = player_id;
    out_next.button_out = hold_button;
    out_next.level      = hold_level;
    out_next.last       = 1'b0;
    case (state)
      S_IDLE: q_ready = 1'b1;
      S_SRCH: begin
        rd_en   = (lo < hi);
        rd_addr = mid[IDX_W-1:0];
      end
      S_SHIFT_RD: begin
        rd_en   = 1'b1;
        rd_addr = sh_m1[IDX_W-1:0];
      end
      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = sh[IDX_W-1:0];
      end
      S_INS_WR: begin
        wr_en              = 1'b1;
        wr_data.key        = cur.key;
        wr_data.low        = cur.low;
        wr_data.high       = cur.high;
        wr_data.dest       = cur.dest;
        wr_data.last_value = '0;
        wr_data.level      = 1'b0;
      end
      S_EMIT: begin
        out_load            = out_free;
        out_next.kind       = full ? KIND_FULL : KIND_INSERT;
        out_next.button_out = cur.dest;
        out_next.level      = 1'b0;
        out_next.last       = 1'b1;
      end
      S_BACK_RD: begin
        rd_en   = (pos != '0);
        rd_addr = pos_m1[IDX_W-1:0];
      end
      S_FWD_RD: rd_en = (pos < count);
      S_FWD_CHK: begin
        wr_en              = key_match && walk_go && changed;
        wr_data.last_value = cur.value;
        wr_data.level      = new_level;
        out_load           = key_match && walk_go && report && hold_valid;
      end
      S_FLUSH: begin
        out_load      = hold_valid && out_free;
        out_next.last = 1'b1;
      end
      default: q_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      cur <= q_item;
    end
    if (out_load) begin
      out_item <= out_next;
    end
    if (state == S_FWD_CHK && key_match && walk_go && report) begin
      hold_button <= rdata.dest;
      hold_level  <= new_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      player_id  <= 8'd0;
      count      <= '0;
      lo         <= '0;
      hi         <= '0;
      pos        <= '0;
      sh         <= '0;
      hit        <= 1'b0;
      full       <= 1'b0;
      hold_valid <= 1'b0;
      res_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        player_id <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            lo         <= '0;
            hi         <= count;
            sh         <= count;
            hit        <= 1'b0;
            hold_valid <= 1'b0;
            res_cnt    <= '0;
            full       <= (q_item.op == OP_INSERT) && (count == CNT_W'(TABLE_DEPTH));
          end
        end
        S_SRCH: begin
          if (!(lo < hi)) begin
            pos <= lo;
          end
        end
        S_CMP: begin
          if (cur.key < rdata.key) begin
            hi <= mid;
          end else if (cur.key > rdata.key) begin
            lo <= mid + CNT_W'(1);
          end else begin
            pos <= mid;
            hit <= 1'b1;
          end
        end
        S_SHIFT_WR: sh <= sh_m1;
        S_INS_WR:   count <= count + CNT_W'(1);
        S_BACK_CMP: begin
          if (key_match) begin
            pos <= pos_m1;
          end
        end
        S_FWD_CHK: begin
          if (key_match && walk_go) begin
            pos <= pos + CNT_W'(1);
            if (report) begin
              hold_valid <= 1'b1;
              res_cnt    <= res_cnt + RES_W'(1);
            end
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            hold_valid <= 1'b0;
          end
        end
        default: hit <= hit;
      endcase
    end
  end

  `SRM_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(TABLE_DEPTH))
  `SRM_ASSERT_IMPL(a_res_bound, clk, rst, 1'b1, res_cnt <= RES_W'(MAX_RESULTS))
  `SRM_ASSERT_IMPL(a_hold_walk, clk, rst, hold_valid,
    state == S_FWD_RD || state == S_FWD_CHK || state == S_FLUSH || state == S_IDLE)
  `SRM_ASSERT_IMPL(a_load_free, clk, rst, out_load, !out_valid || out_ready)
  `SRM_ASSERT_NEXT(a_insert_count, clk, rst, state == S_INS_WR,
    count == $past(count) + CNT_W'(1))

endmodule

>>> sv/sorted_input_range_mapper.sv
// Top level of the sorted input range mapper.
// Usage: the in channel (in_valid/in_ready/in_item) carries one command per
// transaction: an insert places a mapping entry into a table kept sorted by
// source id, an event updates every entry with that source id. The out channel
// (out_valid/out_ready/out_item) returns results; last marks the final result
// of a command. An insert gives exactly one result (inserted or table full);
// an event gives one result per level change, at most sixteen, or none.
// The cfg_we/cfg_wdata port writes the player id; write it only while idle.
// A two-entry command queue sits between the input and the executor, so new
// transactions are taken while the executor is busy or the receiver stalls.
// One table memory port sets the pace. A full-table insert goes straight to
// its result. Otherwise a binary search reads and compares one entry per
// probe, up to ceil(log2(N+1)) probes for N entries; an insert then moves
// each later entry with a read and a write, and an event walks back over and
// forward through the matching entries with a read and a check for each.
// A stalled receiver holds the executor once one result is waiting and one
// more is held back to learn whether it is the last.
// Reset (rst, synchronous) empties the table and clears the player id to 0.
module sorted_input_range_mapper #(
  parameter int TABLE_DEPTH = srm_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  srm_pkg::in_item_t  in_item,
  input  logic               in_valid,
  output logic               in_ready,
  output srm_pkg::out_item_t out_item,
  output logic               out_valid,
  input  logic               out_ready
);
  import srm_pkg::*;

  cmd_t q_item;
  logic q_valid;
  logic q_ready;

  srm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready)
  );

  srm_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

>>> test/sorted_input_range_mapper_test.sv
// Self-checking testbench for the sorted input range mapper, with a predicting scoreboard.
module sorted_input_range_mapper_test;
  import srm_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int LIMIT = 500000;
  localparam int DRAIN = 200;

  class mapper_scoreboard;
    logic [7:0] player = '0;
    int count = 0;
    entry_t slots [DEPTH];
    out_item_t due [$];
    int unsigned errors = 0;

    function string show(out_item_t r);
      return $sformatf("kind=%0d player=%0d button=%h level=%0d last=%0d",
                       r.kind, r.player_out, r.button_out, r.level, r.last);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function out_item_t result(logic [1:0] kind, logic [15:0] dest, logic lvl, logic fin);
      out_item_t r;
      r.kind = kind;
      r.player_out = player;
      r.button_out = dest;
      r.level = lvl;
      r.last = fin;
      return r;
    endfunction

    function int locate(logic [15:0] key, output bit hit);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = count;
      hit = 1'b0;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (key < slots[mid].key) begin
          hi = mid;
        end else if (key > slots[mid].key) begin
          lo = mid + 1;
        end else begin
          hit = 1'b1;
          return mid;
        end
      end
      return lo;
    endfunction

    // Works out the results that one accepted transaction will produce.
    function void note(in_item_t it);
      int pos;
      bit hit;
      int n;
      logic lvl;
      out_item_t tail;
      if (op_t'(it.cmd) == OP_INSERT) begin
        if (count >= DEPTH) begin
          due.push_back(result(KIND_FULL, it.dest_button, 1'b0, 1'b1));
          return;
        end
        pos = locate(it.source_id, hit);
        for (int i = count; i > pos; i--) begin
          slots[i] = slots[i - 1];
        end
        slots[pos].key = it.source_id;
        slots[pos].low = it.range_low;
        slots[pos].high = it.range_high;
        slots[pos].dest = it.dest_button;
        slots[pos].last_value = '0;
        slots[pos].level = 1'b0;
        count++;
        due.push_back(result(KIND_INSERT, it.dest_button, 1'b0, 1'b1));
        return;
      end
      pos = locate(it.source_id, hit);
      if (!hit) begin
        return;
      end
      while (pos > 0 && slots[pos - 1].key == it.source_id) begin
        pos--;
      end
      n = 0;
      while (pos < count && slots[pos].key == it.source_id) begin
        if (it.source_value != slots[pos].last_value) begin
          slots[pos].last_value = it.source_value;
          lvl = ($signed(it.source_value) >= $signed(slots[pos].low)) &&
                ($signed(it.source_value) <= $signed(slots[pos].high));
          if (lvl != slots[pos].level) begin
            slots[pos].level = lvl;
            if (n < MAX_RESULTS) begin
              due.push_back(result(KIND_LEVEL, slots[pos].dest, lvl, 1'b0));
              n++;
            end
          end
        end
        pos++;
      end
      if (n > 0) begin
        tail = due.pop_back();
        tail.last = 1'b1;
        due.push_back(tail);
      end
    endfunction

    function void check(out_item_t got);
      out_item_t want;
      if (due.size() == 0) begin
        flag({"unexpected result: ", show(got)});
        return;
      end
      want = due.pop_front();
      if (got.kind !== want.kind || got.player_out !== want.player_out ||
          got.button_out !== want.button_out || got.level !== want.level ||
          got.last !== want.last) begin
        flag({"mismatch: expected ", show(want), ", got ", show(got)});
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;
  in_item_t in_item = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  out_item_t out_item;
  logic out_valid;
  logic out_ready = 1'b0;
  bit steady = 1'b0;
  int unsigned cycles = 0;
  logic signed [15:0] prev_value = '0;
  mapper_scoreboard sb = new();

  sorted_input_range_mapper #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_item(in_item),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .out_item(out_item),
    .out_valid(out_valid),
    .out_ready(out_ready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 23);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.note(in_item);
      end
      if (out_valid && out_ready) begin
        sb.check(out_item);
      end
    end
    cycles++;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic in_item_t mk_insert(logic [15:0] key, logic [15:0] low,
                                         logic [15:0] high, logic [15:0] dest);
    in_item_t it;
    it.cmd = OP_INSERT;
    it.source_id = key;
    it.source_value = 16'($urandom);
    it.range_low = low;
    it.range_high = high;
    it.dest_button = dest;
    return it;
  endfunction

  function automatic in_item_t mk_event(logic [15:0] key, logic [15:0] value);
    in_item_t it;
    it.cmd = OP_EVENT;
    it.source_id = key;
    it.source_value = value;
    it.range_low = 16'($urandom);
    it.range_high = 16'($urandom);
    it.dest_button = 16'($urandom);
    return it;
  endfunction

  // Most keys come from a small pool so that equal keys pile up in the table.
  function automatic logic [15:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'h5A5A;
      4: return 16'h0000;
      5: return 16'hFFFF;
      6, 7: return 16'h0100;
      8: return 16'h0101;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_cmd();
    logic signed [15:0] lo;
    logic signed [15:0] v;
    logic [15:0] key;
    if ($urandom_range(0, 99) < 20) begin
      lo = 16'($urandom_range(0, 2000)) - 16'sd1000;
      case ($urandom_range(0, 3))
        0: return mk_insert(pick_key(), 16'($urandom), 16'($urandom), 16'($urandom));
        1: return mk_insert(pick_key(), lo, lo + 16'($urandom_range(0, 1500)),
                            16'($urandom));
        2: return mk_insert(pick_key(), 16'sh8000, 16'($urandom), 16'($urandom));
        default: return mk_insert(pick_key(), lo, lo - 16'($urandom_range(1, 500)),
                                  16'($urandom));
      endcase
    end
    key = ($urandom_range(0, 99) < 15) ? 16'($urandom) : pick_key();
    case ($urandom_range(0, 4))
      0: v = 16'($urandom);
      1: v = 16'($urandom_range(0, 3000)) - 16'sd1500;
      2: v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      3: v = '0;
      default: v = prev_value;
    endcase
    prev_value = v;
    return mk_event(key, v);
  endfunction

  task automatic push_cmd(input in_item_t it);
    if (!steady && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 23);
    end
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_player(input logic [7:0] p);
    cfg_we <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.player = p;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN) @(posedge clk);
  endtask

  initial begin
    in_item_t plan [$];
    logic [7:0] players [4];
    players[0] = 8'hFF;
    players[1] = 8'h00;
    players[2] = 8'($urandom);
    players[3] = 8'h80;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    plan.push_back(mk_event(16'h0000, 16'sd5));
    plan.push_back(mk_insert(16'h5A5A, 16'sh8000, 16'sh7FFF, 16'hFFFF));
    plan.push_back(mk_insert(16'hFFFF, 16'sh7FFF, 16'sh7FFF, 16'h0000));
    plan.push_back(mk_insert(16'h0000, 16'sh8000, 16'sh8000, 16'h0001));
    plan.push_back(mk_insert(16'h5A5A, 16'sd1, 16'hFFFF, 16'h8000));
    plan.push_back(mk_insert(16'h5A5A, 16'sd0, 16'sd100, 16'h1234));
    plan.push_back(mk_insert(16'h5A5A, 16'hFF9C, 16'hFFFF, 16'hABCD));
    plan.push_back(mk_event(16'h5A5A, 16'sd0));
    plan.push_back(mk_event(16'h5A5A, 16'sd50));
    plan.push_back(mk_event(16'h5A5A, 16'sd50));
    plan.push_back(mk_event(16'h5A5A, 16'sh8000));
    plan.push_back(mk_event(16'h5A5A, 16'hFFCE));
    plan.push_back(mk_event(16'hFFFF, 16'sh7FFF));
    plan.push_back(mk_event(16'h0000, 16'sh8000));
    plan.push_back(mk_event(16'h1111, 16'sd7));
    plan.push_back(mk_event(16'hFFFF, 16'hFFFF));
    plan.push_back(mk_event(16'h0000, 16'sd0));

    write_player(players[0]);
    foreach (plan[i]) begin
      push_cmd(plan[i]);
    end
    settle();

    for (int ph = 1; ph < 4; ph++) begin
      write_player(players[ph]);
      steady = (ph == 2);
      repeat (150) push_cmd(random_cmd());
      settle();
    end

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
